// File: src/evt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the encoder angle and velocity tracker.
// Depends on nothing; every other file of the block imports it.
package evt_pkg;

	// Sample and correction memory geometry.
	localparam int RAW_W   = 14;
	localparam int TAB_N   = 128;
	localparam int TAB_AW  = 7;
	localparam int TAB_W   = 16;
	localparam int FRAC_W  = RAW_W - TAB_AW;
	localparam int ANG_W   = 18;
	localparam int TURN_W  = 20;

	// Velocity history: the last taps minus one velocities.
	localparam int HIST_N  = 39;
	localparam int HIST_AW = 6;

	// Constant divider: three chunks of 18 bits, remainder below 25.
	localparam int DIV_W   = 54;
	localparam int CHUNK_W = 18;
	localparam int N_CHUNK = 3;
	localparam int REM_W   = 5;
	localparam int X_W     = REM_W + CHUNK_W;
	localparam int PROD_W  = 47;
	localparam logic [23:0] RECIP_5  = 24'd3355444;
	localparam logic [23:0] RECIP_25 = 24'd10737419;

	// Fixed-point constants (Q.16 radians).
	localparam logic signed [19:0] TWO_PI      = 20'sd411775;
	localparam logic signed [22:0] WRAP_LIM    = 23'sd196608;
	localparam logic signed [22:0] TWO_PI_23   = 23'sd411775;
	localparam logic signed [20:0] TWO_PI_21   = 21'sd411775;
	localparam logic signed [18:0] HALF_REV    = 19'sd8192;
	localparam logic [18:0]        TWO_PI_U    = 19'd411775;
	localparam logic signed [39:0] VEL_BIAS    = 40'sd171798691840;
	localparam logic signed [39:0] AVG_ROUND   = 40'sd20;
	localparam logic signed [57:0] FILT_BIAS   = 58'sd28147497671065600;
	localparam logic signed [57:0] FILT_ROUND  = 58'sd50;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ANG, ST_POS, ST_RAD, ST_VEL, ST_SUM,
		ST_DIV1, ST_EVEL, ST_FIL, ST_DIV2, ST_OUT
	} evt_state_t;

	typedef enum logic [1:0] {
		CFG_POLE_PAIRS, CFG_ELEC_OFFSET, CFG_MECH_OFFSET, CFG_SAMPLE_RATE
	} cfg_idx_t;

	typedef enum logic {DIV_BY5, DIV_BY25} div_sel_t;

	typedef struct packed {
		logic     start;
		div_sel_t sel;
	} div_req_t;

	typedef enum logic {OP_SAMPLE, OP_TABLE} opcode_t;

	function automatic logic [39:0] sat_40(input logic signed [41:0] x);
		if (x > 42'sd549755813887)
			return 40'h7FFFFFFFFF;
		else if (x < -42'sd549755813888)
			return 40'h8000000000;
		else
			return x[39:0];
	endfunction

	function automatic logic [31:0] sat_32(input logic signed [43:0] x);
		if (x > 44'sd2147483647)
			return 32'h7FFFFFFF;
		else if (x < -44'sd2147483648)
			return 32'h80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic [37:0] sat_38(input logic signed [39:0] x);
		if (x > 40'sd137438953471)
			return 38'h1FFFFFFFFF;
		else if (x < -40'sd137438953472)
			return 38'h2000000000;
		else
			return x[37:0];
	endfunction

endpackage

// File: src/evt_corr_mem.sv
`timescale 1ns / 1ps
// Correction memory: one write port, two registered read ports, valid bit per entry.
// Depends on evt_pkg.
module evt_corr_mem import evt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [TAB_AW-1:0]        waddr,
	input  logic signed [TAB_W-1:0]  wdata,
	input  logic                     re,
	input  logic [TAB_AW-1:0]        raddr_a,
	input  logic [TAB_AW-1:0]        raddr_b,
	output logic signed [TAB_W-1:0]  rdata_a,
	output logic signed [TAB_W-1:0]  rdata_b
);

	logic signed [TAB_W-1:0] mem [TAB_N];
	logic [TAB_N-1:0]        valid_q;
	logic signed [TAB_W-1:0] rd_a_q, rd_b_q;
	logic                    va_q, vb_q;

	// Storage array, no reset.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	// Valid bits stand in for the all-zero reset contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (we)
				valid_q[waddr] <= 1'b1;
			if (re) begin
				va_q <= valid_q[raddr_a];
				vb_q <= valid_q[raddr_b];
			end
		end
	end

	// An entry never written reads as zero.
	assign rdata_a = va_q ? rd_a_q : '0;
	assign rdata_b = vb_q ? rd_b_q : '0;

endmodule

// File: src/evt_vel_hist.sv
`timescale 1ns / 1ps
// Velocity history: circular memory of the last velocities with a fill count.
// Depends on evt_pkg.
module evt_vel_hist import evt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic               wr_en,
	input  logic signed [31:0] wr_data,
	output logic signed [31:0] rd_data
);

	logic signed [31:0] mem [HIST_N];
	logic [HIST_AW-1:0] ptr_q;
	logic [HIST_AW-1:0] fill_q;
	logic signed [31:0] rd_q;
	logic               full_q;

	// The entry at the pointer is the oldest one; it is replaced next.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[ptr_q] <= wr_data;
		if (rd_en)
			rd_q <= mem[ptr_q];
	end

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
			full_q <= 1'b0;
		end else begin
			if (rd_en)
				full_q <= (fill_q == HIST_AW'(HIST_N));
			if (wr_en) begin
				ptr_q <= (ptr_q == HIST_AW'(HIST_N - 1)) ? '0 : ptr_q + 1'b1;
				if (fill_q != HIST_AW'(HIST_N))
					fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Entries not yet written read as zero.
	assign rd_data = full_q ? rd_q : '0;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= HIST_AW'(HIST_N))
		else $error("history fill count beyond depth");
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q < HIST_AW'(HIST_N))
		else $error("history pointer beyond depth");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && fill_q < HIST_AW'(HIST_N)) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("history fill count did not advance on write");
`endif

endmodule

// File: src/evt_const_div.sv
`timescale 1ns / 1ps
// Division of an unsigned word by five or twenty-five, one 18-bit chunk per cycle.
// Depends on evt_pkg.
module evt_const_div import evt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [DIV_W-1:0] dividend,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic             busy_q, done_q;
	logic [1:0]       cnt_q;
	div_sel_t         sel_q;
	logic [REM_W-1:0] rem_q;
	logic [DIV_W-1:0] shf_q, quot_q;
	logic [X_W-1:0]   x;
	logic [23:0]      recip;
	logic [PROD_W-1:0] prod;
	logic [CHUNK_W-1:0] qc;
	logic [X_W-1:0]   qd;
	logic [X_W-1:0]   rnext;

	// One chunk step: reciprocal multiply, then remainder by shift and add.
	always_comb begin
		x     = {rem_q, shf_q[DIV_W-1 -: CHUNK_W]};
		recip = (sel_q == DIV_BY25) ? RECIP_25 : RECIP_5;
		prod  = PROD_W'(x) * PROD_W'(recip);
		if (sel_q == DIV_BY25) begin
			qc = prod[45:28];
			qd = (X_W'(qc) << 4) + (X_W'(qc) << 3) + X_W'(qc);
		end else begin
			qc = prod[41:24];
			qd = (X_W'(qc) << 2) + X_W'(qc);
		end
		rnext = x - qd;
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'(N_CHUNK - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			shf_q <= dividend;
			rem_q <= '0;
			sel_q <= req.sel;
		end else if (busy_q) begin
			shf_q  <= shf_q << CHUNK_W;
			rem_q  <= rnext[REM_W-1:0];
			quot_q <= {quot_q[DIV_W-CHUNK_W-1:0], qc};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// File: src/encoder_angle_velocity_tracker_core.sv
`timescale 1ns / 1ps
// Top level of the encoder angle and velocity tracker: sequencer, state and datapath.
// Depends on evt_pkg, evt_corr_mem, evt_vel_hist and evt_const_div.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------------
//   input    | in_valid / in_stall | opcode, raw_angle, table_index, table_value
//   output   | out_valid/out_stall | raw_echo, mech_position, elec_position,
//            |                     | mech_velocity, elec_velocity, elec_velocity_filtered
//   config   | cfg_we              | cfg_index, cfg_data
//
// A table write transaction is taken while idle and leaves the block idle. An angle
// sample holds the input stalled from acceptance until its result is loaded, so no new
// transaction is taken while a sample is in flight; that span includes the two passes of
// the chunked constant divider. The next transaction is taken once the result sits in
// the output register, even while that register is stalled.
// Reset clears the correction table, the history and all tracking state at once.
module encoder_angle_velocity_tracker_core import evt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [0:0]          opcode,
	input  logic [RAW_W-1:0]    raw_angle,
	input  logic [TAB_AW-1:0]   table_index,
	input  logic signed [15:0]  table_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [RAW_W-1:0]    raw_echo,
	output logic signed [39:0]  mech_position,
	output logic [18:0]         elec_position,
	output logic signed [31:0]  mech_velocity,
	output logic signed [37:0]  elec_velocity,
	output logic signed [37:0]  elec_velocity_filtered,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [39:0]         cfg_data
);

	evt_state_t state_q, state_nx;

	// Configuration registers.
	logic [6:0]         pp_q;
	logic signed [19:0] eoff_q;
	logic signed [39:0] moff_q;
	logic [19:0]        sr_q;

	// Tracking state.
	logic                      have_prev_q;
	logic signed [TURN_W-1:0]  turn_q;
	logic signed [ANG_W-1:0]   prev_cnt_q;
	logic signed [21:0]        prev_sgl_q;
	logic signed [37:0]        sum_q;
	logic signed [47:0]        filt_q;

	// Per-sample working registers.
	logic [RAW_W-1:0]          raw_q;
	logic signed [ANG_W-1:0]   angle_q;
	logic signed [54:0]        prod_pos_q;
	logic signed [37:0]        prod_sgl_q;
	logic [13:0]               ec_q;
	logic [32:0]               prod_ec_q;
	logic signed [39:0]        mpos_q;
	logic signed [22:0]        dang_q;
	logic [18:0]               elec_q;
	logic signed [31:0]        vel_q;
	logic signed [31:0]        mvel_q;
	logic signed [37:0]        evel_q;

	// Output register.
	logic                      out_valid_q;
	logic [RAW_W-1:0]          o_raw_q;
	logic signed [39:0]        o_mpos_q;
	logic [18:0]               o_elec_q;
	logic signed [31:0]        o_mvel_q;
	logic signed [37:0]        o_evel_q;
	logic signed [37:0]        o_filt_q;

	logic in_acc, sample_acc, table_acc, out_load;

	// Submodule connections.
	logic signed [TAB_W-1:0] tab_a, tab_b;
	logic signed [31:0]      hist_old;
	div_req_t                div_req;
	logic [DIV_W-1:0]        div_dividend, div_quot;
	logic                    div_done;

	// Combinational datapath signals.
	logic signed [16:0]        cdiff;
	logic signed [24:0]        iprod;
	logic signed [ANG_W-1:0]   angle_nx;
	logic signed [18:0]        tdiff;
	logic signed [TURN_W-1:0]  turn_nx;
	logic signed [34:0]        posc;
	logic signed [24:0]        ecprod;
	logic signed [54:0]        tpos;
	logic signed [40:0]        pos;
	logic signed [41:0]        mdiff;
	logic signed [37:0]        tsgl;
	logic signed [21:0]        single;
	logic signed [22:0]        dang0, dang;
	logic [32:0]               tec;
	logic signed [20:0]        e0, e1, e2;
	logic signed [43:0]        vprod;
	logic signed [38:0]        total;
	logic signed [39:0]        nvel;
	logic signed [39:0]        eprod;
	logic signed [57:0]        fx, f99, evx, nfil;
	logic signed [48:0]        tfilt;
	logic signed [39:0]        fout;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign sample_acc = in_acc && (opcode == 1'(OP_SAMPLE));
	assign table_acc  = in_acc && (opcode == 1'(OP_TABLE));
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	evt_corr_mem u_corr (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (table_acc),
		.waddr   (table_index),
		.wdata   (table_value),
		.re      (sample_acc),
		.raddr_a (raw_angle[RAW_W-1 -: TAB_AW]),
		.raddr_b (raw_angle[RAW_W-1 -: TAB_AW] + 1'b1),
		.rdata_a (tab_a),
		.rdata_b (tab_b)
	);

	evt_vel_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (sample_acc),
		.wr_en   (state_q == ST_SUM),
		.wr_data (vel_q),
		.rd_data (hist_old)
	);

	evt_const_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Next state and divider requests.
	always_comb begin
		state_nx      = state_q;
		div_req.start = 1'b0;
		div_req.sel   = DIV_BY5;
		case (state_q)
			ST_IDLE: begin
				if (sample_acc)
					state_nx = ST_ANG;
			end
			ST_ANG:  state_nx = ST_POS;
			ST_POS:  state_nx = ST_RAD;
			ST_RAD:  state_nx = ST_VEL;
			ST_VEL:  state_nx = ST_SUM;
			ST_SUM: begin
				div_req.start = 1'b1;
				state_nx      = ST_DIV1;
			end
			ST_DIV1: begin
				if (div_done)
					state_nx = ST_EVEL;
			end
			ST_EVEL: state_nx = ST_FIL;
			ST_FIL: begin
				div_req.start = 1'b1;
				div_req.sel   = DIV_BY25;
				state_nx      = ST_DIV2;
			end
			ST_DIV2: begin
				if (div_done)
					state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (out_load)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// Arithmetic of each step.
	always_comb begin
		// Interpolation between the two table entries.
		cdiff    = {tab_b[15], tab_b} - {tab_a[15], tab_a};
		iprod    = cdiff * $signed({1'b0, raw_q[FRAC_W-1:0]});
		angle_nx = $signed({4'b0, raw_q}) + $signed({{2{tab_a[15]}}, tab_a})
			+ $signed(iprod[24:FRAC_W]);

		// Turn counting on jumps larger than half a turn.
		tdiff   = {angle_q[17], angle_q} - {prev_cnt_q[17], prev_cnt_q};
		turn_nx = turn_q;
		if (have_prev_q) begin
			if (tdiff > HALF_REV) begin
				if (turn_q != {1'b1, {(TURN_W-1){1'b0}}})
					turn_nx = turn_q - 1'b1;
			end else if (tdiff < -HALF_REV) begin
				if (turn_q != {1'b0, {(TURN_W-1){1'b1}}})
					turn_nx = turn_q + 1'b1;
			end
		end
		posc   = $signed({turn_nx[TURN_W-1], turn_nx, 14'b0})
			+ $signed({{17{angle_q[17]}}, angle_q});
		ecprod = $signed({1'b0, pp_q}) * angle_q;

		// Radian conversions with round half up.
		tpos  = prod_pos_q + 55'sd8192;
		pos   = tpos[54:14];
		mdiff = {pos[40], pos} - {{2{moff_q[39]}}, moff_q};
		tsgl  = prod_sgl_q + 38'sd8192;
		single = tsgl[35:14];
		dang0 = {single[21], single} - {prev_sgl_q[21], prev_sgl_q};
		dang  = dang0;
		if (dang0 < -WRAP_LIM)
			dang = dang0 + TWO_PI_23;
		else if (dang0 > WRAP_LIM)
			dang = dang0 - TWO_PI_23;

		// Electrical angle, wrapped twice.
		tec = prod_ec_q + 33'd8192;
		e0  = $signed({2'b0, tec[32:14]}) + $signed({eoff_q[19], eoff_q});
		e1  = e0;
		if (e0 < 0)
			e1 = e0 + TWO_PI_21;
		else if (e0 > TWO_PI_21)
			e1 = e0 - TWO_PI_21;
		e2 = e1;
		if (e1 < 0)
			e2 = e1 + TWO_PI_21;
		else if (e1 > TWO_PI_21)
			e2 = e1 - TWO_PI_21;
		vprod = dang_q * $signed({1'b0, sr_q});

		// Average: biased so the division by forty works on a positive word.
		total = $signed({sum_q[37], sum_q}) + $signed({{7{vel_q[31]}}, vel_q});
		nvel  = $signed({total[38], total}) + VEL_BIAS + AVG_ROUND;

		// Electrical velocity and the low-pass update, biased for division by a hundred.
		eprod = mvel_q * $signed({1'b0, pp_q});
		fx    = $signed({{10{filt_q[47]}}, filt_q});
		f99   = (fx <<< 6) + (fx <<< 5) + (fx <<< 1) + fx;
		evx   = $signed({{20{evel_q[37]}}, evel_q}) <<< 10;
		nfil  = f99 + evx + FILT_ROUND + FILT_BIAS;

		if (state_q == ST_FIL)
			div_dividend = nfil[55:2];
		else
			div_dividend = {19'b0, nvel[37:3]};

		tfilt = $signed({filt_q[47], filt_q}) + 49'sd512;
		fout  = $signed({tfilt[48], tfilt[48:10]});
	end

	// Configuration and tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q        <= 7'd1;
			eoff_q      <= '0;
			moff_q      <= '0;
			sr_q        <= 20'd4000;
			have_prev_q <= 1'b0;
			turn_q      <= '0;
			prev_cnt_q  <= '0;
			prev_sgl_q  <= '0;
			sum_q       <= '0;
			filt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_POLE_PAIRS:  pp_q <= cfg_data[6:0];
					CFG_ELEC_OFFSET: eoff_q <= cfg_data[19:0];
					CFG_MECH_OFFSET: begin
						moff_q      <= cfg_data;
						have_prev_q <= 1'b0;
					end
					CFG_SAMPLE_RATE: sr_q <= cfg_data[19:0];
					default: ;
				endcase
			end
			if (state_q == ST_POS) begin
				turn_q      <= turn_nx;
				have_prev_q <= 1'b1;
				prev_cnt_q  <= angle_q;
			end
			if (state_q == ST_RAD)
				prev_sgl_q <= single;
			if (state_q == ST_SUM)
				sum_q <= sum_q + $signed({{6{vel_q[31]}}, vel_q})
					- $signed({{6{hist_old[31]}}, hist_old});
			if (state_q == ST_DIV2 && div_done)
				filt_q <= div_quot[47:0];
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Working registers of the sample in flight.
	always_ff @(posedge clk) begin
		if (sample_acc)
			raw_q <= raw_angle;
		case (state_q)
			ST_ANG: angle_q <= angle_nx;
			ST_POS: begin
				prod_pos_q <= posc * TWO_PI;
				prod_sgl_q <= angle_q * TWO_PI;
				ec_q       <= ecprod[13:0];
			end
			ST_RAD: begin
				mpos_q    <= sat_40(mdiff);
				dang_q    <= dang;
				prod_ec_q <= 33'(ec_q) * 33'(TWO_PI_U);
			end
			ST_VEL: begin
				elec_q <= e2[18:0];
				vel_q  <= sat_32(vprod);
			end
			ST_DIV1: begin
				if (div_done)
					mvel_q <= div_quot[31:0];
			end
			ST_EVEL: evel_q <= sat_38(eprod);
			default: ;
		endcase
		if (out_load) begin
			o_raw_q  <= raw_q;
			o_mpos_q <= mpos_q;
			o_elec_q <= elec_q;
			o_mvel_q <= mvel_q;
			o_evel_q <= evel_q;
			o_filt_q <= sat_38(fout);
		end
	end

	assign out_valid              = out_valid_q;
	assign raw_echo               = o_raw_q;
	assign mech_position          = o_mpos_q;
	assign elec_position          = o_elec_q;
	assign mech_velocity          = o_mvel_q;
	assign elec_velocity          = o_evel_q;
	assign elec_velocity_filtered = o_filt_q;

`ifndef SYNTHESIS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (state_q == ST_IDLE))
		else $error("input transaction taken outside idle");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider finished while not awaited");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid)
		else $error("loaded result not presented");
	a_elec_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (elec_position <= TWO_PI_U))
		else $error("electrical angle out of range");
`endif

endmodule
